// ----- rtl/ddsel_pkg.sv -----
// ----------------------------------------------------------------------------
// ddsel_pkg
// Shared types, constants and helper functions for the distinct descriptor
// select block.
// ----------------------------------------------------------------------------
package ddsel_pkg;

    // Default sizing of the descriptor set.
    localparam int MAX_OBS_DEF    = 32;
    localparam int DESC_WORDS_DEF = 4;

    // Fixed widths of the item fields.
    localparam int WORD_W   = 64;
    localparam int IN_WORDS = 4;
    localparam int PC_W     = 7;
    localparam int MEDIAN_W = 9;
    localparam int INDEX_W  = 5;

    typedef logic [WORD_W-1:0] t_word;

    // Control of the median ranking cells.
    typedef struct packed {
        logic clr;
        logic ins;
    } t_rank_ctl;

    // Number of set bits in one descriptor word.
    function automatic logic [PC_W-1:0] popcount64(input t_word v);
        logic [PC_W-1:0] c;
        c = '0;
        for (int b = 0; b < WORD_W; b++) begin
            c = c + PC_W'(v[b]);
        end
        return c;
    endfunction

endpackage

// ----- rtl/ddsel_store.sv -----
// ----------------------------------------------------------------------------
// ddsel_store
// Descriptor memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ddsel_store #(
    parameter int MAX_OBS    = ddsel_pkg::MAX_OBS_DEF,
    parameter int DESC_WORDS = ddsel_pkg::DESC_WORDS_DEF,
    localparam int IDX_W     = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1,
    localparam int DW        = DESC_WORDS * ddsel_pkg::WORD_W
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [DW-1:0]    i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [DW-1:0]    o_rdata
);

    logic [DW-1:0] r_mem [MAX_OBS];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ddsel_dist.sv -----
// ----------------------------------------------------------------------------
// ddsel_dist
// Two-stage Hamming distance pipeline: per-word bit counts, then their sum.
// ----------------------------------------------------------------------------
module ddsel_dist #(
    parameter int DESC_WORDS = ddsel_pkg::DESC_WORDS_DEF,
    localparam int DW        = DESC_WORDS * ddsel_pkg::WORD_W,
    localparam int DIST_W    = $clog2(ddsel_pkg::WORD_W * DESC_WORDS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_a,
    input  logic [DW-1:0]     i_b,
    output logic              o_valid,
    output logic [DIST_W-1:0] o_dist,
    output logic              o_busy
);

    logic [ddsel_pkg::PC_W-1:0] n_pc [DESC_WORDS];
    logic [ddsel_pkg::PC_W-1:0] r_pc [DESC_WORDS];
    logic                       r_v1;
    logic [DIST_W-1:0]          n_sum;
    logic [DIST_W-1:0]          r_sum;
    logic                       r_v2;

    // Bit count of each word of the difference.
    always_comb begin
        for (int w = 0; w < DESC_WORDS; w++) begin
            n_pc[w] = ddsel_pkg::popcount64(i_a[w*ddsel_pkg::WORD_W +: ddsel_pkg::WORD_W] ^
                                            i_b[w*ddsel_pkg::WORD_W +: ddsel_pkg::WORD_W]);
        end
    end

    // Sum of the word counts.
    always_comb begin
        n_sum = '0;
        for (int w = 0; w < DESC_WORDS; w++) begin
            n_sum = n_sum + DIST_W'(r_pc[w]);
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        r_pc  <= n_pc;
        r_sum <= n_sum;
    end

    assign o_valid = r_v2;
    assign o_dist  = r_sum;
    assign o_busy  = r_v1 | r_v2;

endmodule

// ----- rtl/ddsel_rank.sv -----
// ----------------------------------------------------------------------------
// ddsel_rank
// Row of sorting cells: each distance of a row is inserted as it arrives, so
// the cells always hold the row sorted in ascending order.
// ----------------------------------------------------------------------------
module ddsel_rank #(
    parameter int MAX_OBS    = ddsel_pkg::MAX_OBS_DEF,
    parameter int DESC_WORDS = ddsel_pkg::DESC_WORDS_DEF,
    localparam int IDX_W     = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1,
    localparam int CNT_W     = $clog2(MAX_OBS + 1),
    localparam int DIST_W    = $clog2(ddsel_pkg::WORD_W * DESC_WORDS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ddsel_pkg::t_rank_ctl i_ctl,
    input  logic [DIST_W-1:0]    i_value,
    input  logic [IDX_W-1:0]     i_sel,
    output logic [DIST_W-1:0]    o_value,
    output logic [CNT_W-1:0]     o_count
);

    logic [DIST_W-1:0]  r_cell [MAX_OBS];
    logic [DIST_W-1:0]  n_cell [MAX_OBS];
    logic [MAX_OBS-1:0] gt;
    logic [CNT_W-1:0]   r_count;

    // A cell above the fill level counts as larger than any distance.
    // Cells above the new value shift up by one; the first of them takes it.
    for (genvar k = 0; k < MAX_OBS; k++) begin : g_cell
        assign gt[k] = (r_count <= CNT_W'(k)) || (r_cell[k] > i_value);
        if (k == 0) begin : g_first
            assign n_cell[k] = gt[k] ? i_value : r_cell[k];
        end else begin : g_rest
            assign n_cell[k] = !gt[k] ? r_cell[k] :
                               (gt[k-1] ? r_cell[k-1] : i_value);
        end
    end

    // Cell contents.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_cell <= n_cell;
        end
    end

    // Fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clr) begin
            r_count <= '0;
        end else if (i_ctl.ins) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign o_value = r_cell[i_sel];
    assign o_count = r_count;

endmodule

// ----- rtl/distinct_descriptor_select_top.sv -----
// ----------------------------------------------------------------------------
// distinct_descriptor_select_top
// Loads a set of binary descriptors and returns the one whose median Hamming
// distance to the whole set is smallest.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid / o_stall) carries one descriptor per item, with
// skip and last flags. Items are taken one per cycle while loading; a kept
// descriptor is written into the descriptor memory in the cycle it arrives.
// The item flagged last starts the selection, and o_stall stays high until
// the result is placed in the output register. For n kept descriptors the
// selection makes, per row, one memory read for the row, n reads for the
// columns and then waits for the distance pipeline and the sorting cells to
// drain. The descriptor memory has a single read port, so the row and column
// reads go one after another.
// The output channel (o_valid / i_stall) gives one item per set. The output
// register holds it while i_stall is high, and loading of the next set goes
// on meanwhile; only the end of the next selection waits for a free output.
// Reset clears the kept count and the overflow flag, empties both sides of
// the pipeline and needs no pass over the memory.
// ----------------------------------------------------------------------------
module distinct_descriptor_select_top #(
    parameter int MAX_OBS    = ddsel_pkg::MAX_OBS_DEF,
    parameter int DESC_WORDS = ddsel_pkg::DESC_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_desc_w0,
    input  logic [63:0] i_desc_w1,
    input  logic [63:0] i_desc_w2,
    input  logic [63:0] i_desc_w3,
    input  logic        i_skip,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [4:0]  o_best_index,
    output logic [8:0]  o_best_median,
    output logic [63:0] o_best_w0,
    output logic [63:0] o_best_w1,
    output logic [63:0] o_best_w2,
    output logic [63:0] o_best_w3,
    output logic        o_overflow
);

    localparam int IDX_W  = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
    localparam int CNT_W  = $clog2(MAX_OBS + 1);
    localparam int DW     = DESC_WORDS * ddsel_pkg::WORD_W;
    localparam int DIST_W = $clog2(ddsel_pkg::WORD_W * DESC_WORDS + 1);
    localparam int MED_W  = (DIST_W > ddsel_pkg::MEDIAN_W) ? DIST_W : ddsel_pkg::MEDIAN_W;
    localparam int XIDX_W = (IDX_W > ddsel_pkg::INDEX_W) ? IDX_W : ddsel_pkg::INDEX_W;
    localparam int IN_WORDS = ddsel_pkg::IN_WORDS;
    localparam int WORD_W   = ddsel_pkg::WORD_W;

    // Sequencer states.
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_ROWRD = 3'd1;
    localparam logic [2:0] S_COLS  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_ovf, n_ovf;
    logic [IDX_W-1:0]    r_row, n_row;
    logic [IDX_W-1:0]    r_col, n_col;
    logic                r_row_rv, n_row_rv;
    logic                r_col_rv, n_col_rv;
    logic [DW-1:0]       r_row_desc;
    logic [IDX_W-1:0]    r_best, n_best;
    logic [DIST_W-1:0]   r_best_med, n_best_med;
    logic                r_found, n_found;

    logic                r_o_valid, n_o_valid;
    logic                r_o_found;
    logic [ddsel_pkg::INDEX_W-1:0]  r_o_index;
    logic [ddsel_pkg::MEDIAN_W-1:0] r_o_median;
    ddsel_pkg::t_word    r_o_w [IN_WORDS];
    logic                r_o_ovf;

    logic                accept_in;
    logic                out_free;
    logic                load_out;
    logic                cnt_full;
    logic [CNT_W-1:0]    last_idx;
    logic [CNT_W-1:0]    half_full;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [DW-1:0]       mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    logic [DW-1:0]       mem_rdata;

    logic                dist_valid;
    logic [DIST_W-1:0]   dist_value;
    logic                dist_busy;

    ddsel_pkg::t_rank_ctl rank_ctl;
    logic [DIST_W-1:0]   rank_value;
    logic [CNT_W-1:0]    rank_count;

    ddsel_pkg::t_word    in_words [IN_WORDS];
    ddsel_pkg::t_word    fetched [IN_WORDS];
    logic [MED_W-1:0]    med_ext;
    logic [XIDX_W-1:0]   idx_ext;

    // Handshake terms.
    assign accept_in = i_valid && (r_state == S_LOAD);
    assign o_stall   = (r_state != S_LOAD);
    assign out_free  = !r_o_valid || !i_stall;
    assign cnt_full  = (r_cnt == CNT_W'(MAX_OBS));
    assign last_idx  = r_cnt - CNT_W'(1);
    assign half_full = r_cnt >> 1;

    // Input words laid out as one memory word; missing words load as zero.
    assign in_words[0] = i_desc_w0;
    assign in_words[1] = i_desc_w1;
    assign in_words[2] = i_desc_w2;
    assign in_words[3] = i_desc_w3;
    for (genvar w = 0; w < DESC_WORDS; w++) begin : g_wdata
        if (w < IN_WORDS) begin : g_in
            assign mem_wdata[w*WORD_W +: WORD_W] = in_words[w];
        end else begin : g_pad
            assign mem_wdata[w*WORD_W +: WORD_W] = '0;
        end
    end

    // Fetched descriptor words; words beyond the descriptor read as zero.
    for (genvar w = 0; w < IN_WORDS; w++) begin : g_fetch
        if (w < DESC_WORDS) begin : g_word
            assign fetched[w] = mem_rdata[w*WORD_W +: WORD_W];
        end else begin : g_zero
            assign fetched[w] = '0;
        end
    end

    ddsel_store #(
        .MAX_OBS    (MAX_OBS),
        .DESC_WORDS (DESC_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ddsel_dist #(
        .DESC_WORDS (DESC_WORDS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_col_rv),
        .i_a     (r_row_desc),
        .i_b     (mem_rdata),
        .o_valid (dist_valid),
        .o_dist  (dist_value),
        .o_busy  (dist_busy)
    );

    ddsel_rank #(
        .MAX_OBS    (MAX_OBS),
        .DESC_WORDS (DESC_WORDS)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rank_ctl),
        .i_value (dist_value),
        .i_sel   (half_full[IDX_W-1:0]),
        .o_value (rank_value),
        .o_count (rank_count)
    );

    // Sequencer: load, walk every row against every column, then fetch the best and output it.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_row      = r_row;
        n_col      = r_col;
        n_row_rv   = 1'b0;
        n_col_rv   = 1'b0;
        n_best     = r_best;
        n_best_med = r_best_med;
        n_found    = r_found;
        mem_we     = 1'b0;
        mem_waddr  = r_cnt[IDX_W-1:0];
        mem_re     = 1'b0;
        mem_raddr  = r_row;
        rank_ctl.clr = 1'b0;
        rank_ctl.ins = dist_valid;
        load_out   = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (accept_in) begin
                    if (!i_skip) begin
                        if (!cnt_full) begin
                            mem_we = 1'b1;
                            n_cnt  = r_cnt + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_last) begin
                        n_row = '0;
                        if (n_cnt == '0) begin
                            n_found    = 1'b0;
                            n_best     = '0;
                            n_best_med = '0;
                            n_state    = S_OUT;
                        end else begin
                            n_found = 1'b1;
                            n_state = S_ROWRD;
                        end
                    end
                end
            end
            S_ROWRD: begin
                mem_re    = 1'b1;
                mem_raddr = r_row;
                n_row_rv  = 1'b1;
                n_col     = '0;
                n_state   = S_COLS;
            end
            S_COLS: begin
                mem_re    = 1'b1;
                mem_raddr = r_col;
                n_col_rv  = 1'b1;
                if (CNT_W'(r_col) == last_idx) begin
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                // The row is complete once nothing is left in flight.
                if (!r_col_rv && !dist_busy) begin
                    if ((r_row == '0) || (rank_value < r_best_med)) begin
                        n_best     = r_row;
                        n_best_med = rank_value;
                    end
                    rank_ctl.clr = 1'b1;
                    if (CNT_W'(r_row) == last_idx) begin
                        n_state = S_FETCH;
                    end else begin
                        n_row   = r_row + IDX_W'(1);
                        n_state = S_ROWRD;
                    end
                end
            end
            S_FETCH: begin
                mem_re    = 1'b1;
                mem_raddr = r_best;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_cnt    = '0;
                    n_ovf    = 1'b0;
                    n_state  = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_row_rv <= 1'b0;
            r_col_rv <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_row_rv <= n_row_rv;
            r_col_rv <= n_col_rv;
        end
    end

    // Walk counters and running best.
    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_best     <= n_best;
        r_best_med <= n_best_med;
        r_found    <= n_found;
        if (r_row_rv) begin
            r_row_desc <= mem_rdata;
        end
    end

    // Result formatting: saturated median and index modulo the field width.
    assign med_ext = MED_W'(r_best_med);
    assign idx_ext = XIDX_W'(r_best);

    // Output register valid.
    assign n_o_valid = load_out ? 1'b1 : (r_o_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_found <= r_found;
            r_o_index <= idx_ext[ddsel_pkg::INDEX_W-1:0];
            r_o_ovf   <= r_ovf;
            if (med_ext > MED_W'((1 << ddsel_pkg::MEDIAN_W) - 1)) begin
                r_o_median <= '1;
            end else begin
                r_o_median <= med_ext[ddsel_pkg::MEDIAN_W-1:0];
            end
            for (int w = 0; w < IN_WORDS; w++) begin
                r_o_w[w] <= r_found ? fetched[w] : '0;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_found       = r_o_found;
    assign o_best_index  = r_o_index;
    assign o_best_median = r_o_median;
    assign o_best_w0     = r_o_w[0];
    assign o_best_w1     = r_o_w[1];
    assign o_best_w2     = r_o_w[2];
    assign o_best_w3     = r_o_w[3];
    assign o_overflow    = r_o_ovf;

    // The kept count never passes the memory depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_OBS))
        else $error("kept count above the memory depth");

    // Distances reach the sorting cells only during the row walk.
    a_ins_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_valid |-> ((r_state == S_COLS) || (r_state == S_DRAIN)))
        else $error("distance arrived outside the row walk");

    // A drained row has exactly one distance per kept descriptor.
    a_row_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DRAIN) && !r_col_rv && !dist_busy) |-> (rank_count == r_cnt))
        else $error("row median taken from an incomplete row");

    // The last item of a set closes the input until the result is out.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_in && i_last) |=> o_stall)
        else $error("input still open after the last item");

    // An empty set reports zero index and median.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> ((o_best_median == '0) && (o_best_index == '0)))
        else $error("empty set result carries nonzero fields");

endmodule
